### rtl/core/mtse_pkg.sv
`timescale 1ns / 1ps
// Map table package: shared types, field widths and codes.
// Used by mtse_ctrl, mtse_dpath and map_table_size_age_eviction.
package mtse_pkg;

    localparam int TABLE_DEPTH_DEF = 32;

    localparam int SIZE_W  = 24;
    localparam int COORD_W = 16;
    localparam int ID_W    = 32;
    localparam int STAMP_W = 32;
    localparam int CODE_W  = 3;
    localparam int SLOT_OUT_W = 5;
    localparam int CFG_IDX_W  = 2;

    // outcome codes
    localparam logic [CODE_W-1:0] OUT_ADDED   = 3'd0;
    localparam logic [CODE_W-1:0] OUT_EVICTED = 3'd1;
    localparam logic [CODE_W-1:0] OUT_BAD     = 3'd2;
    localparam logic [CODE_W-1:0] OUT_FULL    = 3'd3;
    localparam logic [CODE_W-1:0] OUT_EMPTIED = 3'd4;

    // request kinds
    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_EVICT = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_AREA_LEFT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_TOP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_RIGHT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_BOTTOM = 2'd3;

    typedef struct packed {
        logic               req_type;
        logic [SIZE_W-1:0]  map_size;
        logic [SIZE_W-1:0]  free_amount;
        logic [COORD_W-1:0] corner_left;
        logic [COORD_W-1:0] corner_top;
        logic [COORD_W-1:0] corner_right;
        logic [COORD_W-1:0] corner_bottom;
    } req_word_t;

    typedef struct packed {
        logic [CODE_W-1:0]     outcome;
        logic [SLOT_OUT_W-1:0] slot_index;
        logic [ID_W-1:0]       map_id;
        logic [SIZE_W-1:0]     freed_size;
        logic                  last_result;
    } rsp_word_t;

    typedef struct packed {
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] bottom;
    } area_t;

    // controller -> datapath
    typedef struct packed {
        logic load_req;
        logic add_commit;
        logic scan_start;
        logic scan_run;
        logic evict_commit;
        logic set_bad;
        logic set_full;
        logic set_empty;
        logic fetch_id;
        logic emit;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic req_evict;
        logic req_bad;
        logic table_full;
        logic amount_zero;
        logic scan_done;
        logic victim_found;
        logic res_last;
    } sts_t;

endpackage

### rtl/core/mtse_ctrl.sv
`timescale 1ns / 1ps
// Map table controller: request sequencing state machine.
// Depends on mtse_pkg (cmd_t, sts_t).
module mtse_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           out_free,
    input  mtse_pkg::sts_t sts,
    output mtse_pkg::cmd_t cmd,
    output logic           req_stall
);
    import mtse_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECODE = 7'b0000010,
        S_POP    = 7'b0000100,
        S_SCAN   = 7'b0001000,
        S_PICK   = 7'b0010000,
        S_FETCH  = 7'b0100000,
        S_EMIT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (!sts.req_evict)
                begin
                    if (sts.req_bad)
                    begin
                        cmd.set_bad = 1'b1;
                        state_next  = S_EMIT;
                    end
                    else if (sts.table_full)
                    begin
                        cmd.set_full = 1'b1;
                        state_next   = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_POP;
                    end
                end
                else if (sts.amount_zero)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_POP:
            begin
                cmd.add_commit = 1'b1;
                state_next     = S_EMIT;
            end
            S_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                if (sts.victim_found)
                begin
                    cmd.evict_commit = 1'b1;
                    state_next       = S_FETCH;
                end
                else
                begin
                    cmd.set_empty = 1'b1;
                    state_next    = S_EMIT;
                end
            end
            S_FETCH:
            begin
                cmd.fetch_id = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.res_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // a word is only handed to the output register when it has room
    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free)
        else $error("emit without output room");

    // scanning never skips the victim pick
    a_scan_to_pick: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && sts.scan_done) |=> state_reg == S_PICK)
        else $error("scan did not end in pick");

    // a new request is taken only from idle
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_req |=> state_reg == S_DECODE)
        else $error("request load out of sequence");

endmodule

### rtl/core/mtse_dpath.sv
`timescale 1ns / 1ps
// Map table datapath: entry memories, free-slot stack, counters, victim scan.
// Depends on mtse_pkg; driven by mtse_ctrl commands.
module mtse_dpath #(
    parameter int TABLE_DEPTH = mtse_pkg::TABLE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mtse_pkg::cmd_t      cmd,
    input  mtse_pkg::req_word_t req_word,
    input  mtse_pkg::area_t     area,
    output mtse_pkg::sts_t      sts,
    output mtse_pkg::rsp_word_t result
);
    import mtse_pkg::*;

    localparam int SLOT_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int SCAN_W = $clog2(TABLE_DEPTH + 2);
    localparam int LIM_W  = STAMP_W + 3;
    localparam int S10_W  = STAMP_W + 4;

    localparam logic [CNT_W-1:0]  CNT_FULL   = CNT_W'(TABLE_DEPTH);
    localparam logic [SCAN_W-1:0] SCAN_ISSUE = SCAN_W'(TABLE_DEPTH);
    localparam logic [SCAN_W-1:0] SCAN_LAST  = SCAN_W'(TABLE_DEPTH + 1);

    // request and counters
    req_word_t         req_reg;
    logic [SIZE_W-1:0] amount_reg;
    logic [CNT_W-1:0]  free_count_reg;
    logic [STAMP_W-1:0] age_reg;
    logic [ID_W-1:0]   id_reg;
    logic [LIM_W-1:0]  limit_reg;

    // entry state
    logic [TABLE_DEPTH-1:0] entry_valid_reg;
    logic [SIZE_W-1:0]  size_mem  [TABLE_DEPTH];
    logic [STAMP_W-1:0] stamp_mem [TABLE_DEPTH];
    logic [ID_W-1:0]    ident_mem [TABLE_DEPTH];
    logic [SIZE_W-1:0]  rd_size_reg;
    logic [STAMP_W-1:0] rd_stamp_reg;
    logic [ID_W-1:0]    rd_ident_reg;

    // free-slot stack; an unwritten location holds its own index
    logic [SLOT_W-1:0]      stk_mem [TABLE_DEPTH];
    logic [SLOT_W-1:0]      stk_rd_reg;
    logic [TABLE_DEPTH-1:0] stk_written_reg;

    // scan pipeline
    logic [SCAN_W-1:0] scan_cnt_reg;
    logic              p1_valid_reg, p2_valid_reg, p2_old_reg;
    logic [SLOT_W-1:0] p1_idx_reg, p2_idx_reg;
    logic [SIZE_W-1:0] p2_size_reg;
    logic              any_found_reg, old_found_reg;
    logic [SLOT_W-1:0] any_idx_reg, old_idx_reg;
    logic [SIZE_W-1:0] any_size_reg, old_size_reg;

    rsp_word_t result_reg;

    logic [CNT_W-1:0]      cnt_m1;
    logic [SLOT_W-1:0]     pop_idx;
    logic [SLOT_W-1:0]     new_slot;
    logic [SLOT_W-1:0]     scan_idx;
    logic                  scan_issue;
    logic [SLOT_W-1:0]     victim_idx;
    logic [SIZE_W-1:0]     victim_size;
    logic [SLOT_W-1:0]     rd_addr;
    logic [SIZE_W-1:0]     amount_next;
    logic [S10_W-1:0]      stamp_x10;
    logic                  p1_old;
    logic [STAMP_W-1:0]    age_inc;
    logic [ID_W-1:0]       id_inc;
    logic [SLOT_W+4:0]     new_slot_ext;
    logic [SLOT_W+4:0]     victim_ext;
    logic                  bad;

    assign cnt_m1   = free_count_reg - CNT_W'(1);
    assign pop_idx  = cnt_m1[SLOT_W-1:0];
    assign new_slot = stk_written_reg[pop_idx] ? stk_rd_reg : pop_idx;
    assign scan_idx = scan_cnt_reg[SLOT_W-1:0];
    assign scan_issue = (scan_cnt_reg < SCAN_ISSUE);
    assign victim_idx  = old_found_reg ? old_idx_reg : any_idx_reg;
    assign victim_size = old_found_reg ? old_size_reg : any_size_reg;
    assign rd_addr = cmd.evict_commit ? victim_idx : scan_idx;
    assign amount_next = (victim_size >= amount_reg) ? '0 : amount_reg - victim_size;
    assign age_inc = age_reg + STAMP_W'(1);
    assign id_inc  = id_reg + ID_W'(1);
    assign new_slot_ext = {5'b0, new_slot};
    assign victim_ext   = {5'b0, victim_idx};

    // stamp*10 <= age*7 stands for stamp <= 0.7*age
    assign stamp_x10 = {1'b0, rd_stamp_reg, 3'b000} + {3'b000, rd_stamp_reg, 1'b0};
    assign p1_old    = (stamp_x10 <= {1'b0, limit_reg});

    assign bad = (req_reg.map_size == '0)
              || (req_reg.corner_left > req_reg.corner_right)
              || (req_reg.corner_top > req_reg.corner_bottom)
              || (req_reg.corner_left < area.left)
              || (req_reg.corner_top < area.top)
              || (req_reg.corner_right > area.right)
              || (req_reg.corner_bottom > area.bottom);

    always_comb
    begin
        sts.req_evict    = (req_reg.req_type == REQ_EVICT);
        sts.req_bad      = bad;
        sts.table_full   = (free_count_reg == '0);
        sts.amount_zero  = (amount_reg == '0);
        sts.scan_done    = (scan_cnt_reg == SCAN_LAST);
        sts.victim_found = any_found_reg;
        sts.res_last     = result_reg.last_result;
    end

    assign result = result_reg;

    // entry memories: one write port (add), one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.add_commit)
        begin
            size_mem[new_slot]  <= req_reg.map_size;
            stamp_mem[new_slot] <= age_inc;
            ident_mem[new_slot] <= id_inc;
        end
        rd_size_reg  <= size_mem[rd_addr];
        rd_stamp_reg <= stamp_mem[rd_addr];
        rd_ident_reg <= ident_mem[rd_addr];
    end

    // stack memory: push on evict, read at top for pop
    always_ff @(posedge clk)
    begin
        if (cmd.evict_commit && (free_count_reg < CNT_FULL))
        begin
            stk_mem[free_count_reg[SLOT_W-1:0]] <= victim_idx;
        end
        stk_rd_reg <= stk_mem[pop_idx];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req_word;
        end
        if (cmd.scan_start)
        begin
            limit_reg <= {age_reg, 3'b000} - {3'b000, age_reg};
        end
        if (cmd.scan_run)
        begin
            p1_idx_reg  <= scan_idx;
            p2_idx_reg  <= p1_idx_reg;
            p2_size_reg <= rd_size_reg;
            p2_old_reg  <= p1_old;
        end
        if (cmd.scan_run && p2_valid_reg)
        begin
            if (!any_found_reg || (p2_size_reg > any_size_reg))
            begin
                any_idx_reg  <= p2_idx_reg;
                any_size_reg <= p2_size_reg;
            end
            if (p2_old_reg && (!old_found_reg || (p2_size_reg > old_size_reg)))
            begin
                old_idx_reg  <= p2_idx_reg;
                old_size_reg <= p2_size_reg;
            end
        end
        priority if (cmd.set_bad)
        begin
            result_reg <= '{outcome: OUT_BAD, slot_index: '0, map_id: '0,
                            freed_size: '0, last_result: 1'b1};
        end
        else if (cmd.set_full)
        begin
            result_reg <= '{outcome: OUT_FULL, slot_index: '0, map_id: '0,
                            freed_size: '0, last_result: 1'b1};
        end
        else if (cmd.set_empty)
        begin
            result_reg <= '{outcome: OUT_EMPTIED, slot_index: '0, map_id: '0,
                            freed_size: '0, last_result: 1'b1};
        end
        else if (cmd.add_commit)
        begin
            result_reg <= '{outcome: OUT_ADDED, slot_index: new_slot_ext[4:0],
                            map_id: id_inc, freed_size: '0, last_result: 1'b1};
        end
        else if (cmd.evict_commit)
        begin
            result_reg <= '{outcome: OUT_EVICTED, slot_index: victim_ext[4:0],
                            map_id: '0, freed_size: victim_size,
                            last_result: (amount_next == '0)};
        end
        else if (cmd.fetch_id)
        begin
            result_reg.map_id <= rd_ident_reg;
        end
        else
        begin
            result_reg <= result_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amount_reg      <= '0;
            free_count_reg  <= CNT_FULL;
            age_reg         <= '0;
            id_reg          <= '0;
            entry_valid_reg <= '0;
            stk_written_reg <= '0;
            scan_cnt_reg    <= '0;
            p1_valid_reg    <= 1'b0;
            p2_valid_reg    <= 1'b0;
            any_found_reg   <= 1'b0;
            old_found_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load_req)
            begin
                amount_reg <= req_word.free_amount;
            end
            if (cmd.add_commit)
            begin
                free_count_reg            <= cnt_m1;
                age_reg                   <= age_inc;
                id_reg                    <= id_inc;
                entry_valid_reg[new_slot] <= 1'b1;
            end
            if (cmd.evict_commit)
            begin
                entry_valid_reg[victim_idx] <= 1'b0;
                amount_reg                  <= amount_next;
                if (free_count_reg < CNT_FULL)
                begin
                    stk_written_reg[free_count_reg[SLOT_W-1:0]] <= 1'b1;
                    free_count_reg <= free_count_reg + CNT_W'(1);
                end
            end
            if (cmd.scan_start)
            begin
                scan_cnt_reg  <= '0;
                p1_valid_reg  <= 1'b0;
                p2_valid_reg  <= 1'b0;
                any_found_reg <= 1'b0;
                old_found_reg <= 1'b0;
            end
            else if (cmd.scan_run)
            begin
                scan_cnt_reg <= scan_cnt_reg + SCAN_W'(1);
                p1_valid_reg <= scan_issue && entry_valid_reg[scan_idx];
                p2_valid_reg <= p1_valid_reg;
                if (p2_valid_reg)
                begin
                    any_found_reg <= 1'b1;
                    if (p2_old_reg)
                    begin
                        old_found_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // every slot is either on the free stack or holds a valid entry
    a_slot_count: assert property (@(posedge clk) disable iff (!rst_n)
        ($countones(entry_valid_reg) + int'(free_count_reg)) == TABLE_DEPTH)
        else $error("slot accounting broken");

    // an evicted slot holds a live entry
    a_victim_live: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.evict_commit |-> entry_valid_reg[victim_idx])
        else $error("victim slot not valid");

    // a popped slot is free
    a_pop_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.add_commit |-> !entry_valid_reg[new_slot])
        else $error("popped slot already in use");

endmodule

### rtl/core/map_table_size_age_eviction.sv
`timescale 1ns / 1ps
// Map table with largest/oldest victim replacement: top level.
// Depends on mtse_pkg, mtse_ctrl and mtse_dpath.
//
// Usage:
//   Request channel (req_valid/req_stall/req_word): one word is an add or an
//   evict request. A word is taken when req_valid is high and req_stall low.
//   The block works on one request at a time; req_stall stays high from
//   acceptance until the last result word has been moved to the output
//   register (or, for an evict of zero, until decode is done).
//   Result channel (rsp_valid/rsp_stall/rsp_word): one word for an add, a bad
//   request or a full table; one word per evicted entry, plus an "emptied"
//   word if the table runs dry. last_result marks the final word.
//   Config port (cfg_valid/cfg_ready/cfg_index/cfg_data): area registers,
//   always ready; write only while no request is in flight.
// Sequencing:
//   Add: decode, then slot pop and result load, then emit; a bad input or a
//   full table loads its result during decode. Evict: each victim costs a full
//   table scan through the entry memory read port and the two-stage compare
//   pipe, followed by pick, id fetch and emit.
// Reset: empty table, all slots free, age and id counters zero, area set to
//   the full 16-bit range. A stalled receiver holds the current result; the
//   block waits in its emit step and resumes when the output register frees.
module map_table_size_age_eviction #(
    parameter int TABLE_DEPTH = mtse_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // request channel
    input  logic                                  req_valid,
    output logic                                  req_stall,
    input  mtse_pkg::req_word_t                   req_word,
    // result channel
    output logic                                  rsp_valid,
    input  logic                                  rsp_stall,
    output mtse_pkg::rsp_word_t                   rsp_word,
    // configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mtse_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mtse_pkg::COORD_W-1:0]          cfg_data
);
    import mtse_pkg::*;

    area_t     area_reg;
    cmd_t      cmd;
    sts_t      sts;
    rsp_word_t result;
    logic      rsp_valid_reg;
    rsp_word_t rsp_word_reg;
    logic      out_free;

    // output register frees when empty or when its word leaves this cycle
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    mtse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .out_free  (out_free),
        .sts       (sts),
        .cmd       (cmd),
        .req_stall (req_stall)
    );

    mtse_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req_word (req_word),
        .area     (area_reg),
        .sts      (sts),
        .result   (result)
    );

    // area registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_reg.left   <= '0;
            area_reg.top    <= '0;
            area_reg.right  <= '1;
            area_reg.bottom <= '1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_AREA_LEFT:   area_reg.left   <= cfg_data;
                REG_AREA_TOP:    area_reg.top    <= cfg_data;
                REG_AREA_RIGHT:  area_reg.right  <= cfg_data;
                REG_AREA_BOTTOM: area_reg.bottom <= cfg_data;
                default:         area_reg        <= area_reg;
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            rsp_word_reg <= result;
        end
    end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the map table with largest/oldest victim eviction.
// Depends on mtse_pkg and map_table_size_age_eviction; nothing else.
module tb_top;
    import mtse_pkg::*;

    localparam int DEPTH        = TABLE_DEPTH_DEF;
    localparam int PHASES       = 4;
    localparam int PHASE_ITEMS  = 84;
    // idle tail after each drain, scaled with the table depth
    localparam int IDLE_TAIL    = 2 * (DEPTH + 5);
    localparam int DRAIN_LIMIT  = 50000;
    localparam int LONG_HOLD    = 400;
    // worst case: 33 words per request, each behind a receiver stall, x5
    localparam longint RUN_LIMIT_NS = 64'd20_000_000;

    typedef struct packed {
        req_word_t word;
        logic      typed;   // 1: the single result word below is typed in
        rsp_word_t want;
    } dir_row_t;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_word_t req_word;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_word_t rsp_word;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COORD_W-1:0]   cfg_data;

    // ---- shadow of the block state, kept by the predictor ----
    logic              tbl_used  [DEPTH];
    logic [SIZE_W-1:0] tbl_size  [DEPTH];
    logic [STAMP_W-1:0] tbl_stamp[DEPTH];
    logic [ID_W-1:0]   tbl_id    [DEPTH];
    int                free_stack[DEPTH];
    int                free_top;
    logic [STAMP_W-1:0] age_now;
    logic [ID_W-1:0]   id_now;
    area_t             area_now;

    rsp_word_t expected_words[$];

    int mismatches    = 0;
    int results_seen  = 0;
    int requests_done = 0;
    int tight_run     = 0;   // remaining requests sent back to back
    int outcome_hits [5] = '{0, 0, 0, 0, 0};

    map_table_size_age_eviction #(.TABLE_DEPTH(DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Works out the result words of one accepted request and queues them;
    // updates the shadow table the way the block does.
    function automatic int predict_map_table(input req_word_t w);
        rsp_word_t         r;
        logic [SIZE_W-1:0] still_owed;
        logic [63:0]       old_limit;
        int                slot;
        int                best_old;
        int                best_any;
        int                n;
        n = 0;
        if (w.req_type == REQ_ADD)
        begin
            r = '0;
            r.last_result = 1'b1;
            if (w.map_size == '0 || w.corner_left > w.corner_right ||
                w.corner_top > w.corner_bottom || w.corner_left < area_now.left ||
                w.corner_top < area_now.top || w.corner_right > area_now.right ||
                w.corner_bottom > area_now.bottom)
                r.outcome = OUT_BAD;
            else if (free_top == 0)
                r.outcome = OUT_FULL;
            else
            begin
                // LIFO pop, then both counters advance before the entry is stored
                free_top--;
                slot = free_stack[free_top];
                age_now++;
                id_now++;
                tbl_used[slot]  = 1'b1;
                tbl_size[slot]  = w.map_size;
                tbl_stamp[slot] = age_now;
                tbl_id[slot]    = id_now;
                r.outcome    = OUT_ADDED;
                r.slot_index = slot[SLOT_OUT_W-1:0];
                r.map_id     = id_now;
            end
            expected_words.push_back(r);
            return 1;
        end
        still_owed = w.free_amount;
        while (still_owed != '0)
        begin
            // old enough means stamp*10 <= age*7; largest wins, lowest slot on ties
            best_old  = -1;
            best_any  = -1;
            old_limit = 64'(age_now) * 64'd7;
            for (int i = 0; i < DEPTH; i++)
            begin
                if (tbl_used[i])
                begin
                    if (best_any < 0 || tbl_size[i] > tbl_size[best_any])
                        best_any = i;
                    if (64'(tbl_stamp[i]) * 64'd10 <= old_limit &&
                        (best_old < 0 || tbl_size[i] > tbl_size[best_old]))
                        best_old = i;
                end
            end
            slot = (best_old >= 0) ? best_old : best_any;
            r = '0;
            if (slot < 0)
            begin
                r.outcome     = OUT_EMPTIED;
                r.last_result = 1'b1;
                expected_words.push_back(r);
                return n + 1;
            end
            tbl_used[slot] = 1'b0;
            free_stack[free_top] = slot;
            free_top++;
            r.outcome    = OUT_EVICTED;
            r.slot_index = slot[SLOT_OUT_W-1:0];
            r.map_id     = tbl_id[slot];
            r.freed_size = tbl_size[slot];
            still_owed   = (tbl_size[slot] >= still_owed) ? '0 : still_owed - tbl_size[slot];
            r.last_result = (still_owed == '0);
            expected_words.push_back(r);
            n++;
        end
        return n;
    endfunction

    function automatic req_word_t add_word(input logic [SIZE_W-1:0] size,
                                           input logic [COORD_W-1:0] l, t, r, b);
        req_word_t w;
        w.req_type      = REQ_ADD;
        w.map_size      = size;
        w.free_amount   = SIZE_W'($urandom());   // ignored on an add
        w.corner_left   = l;
        w.corner_top    = t;
        w.corner_right  = r;
        w.corner_bottom = b;
        return w;
    endfunction

    function automatic req_word_t evict_word(input logic [SIZE_W-1:0] amount);
        req_word_t w;
        w.req_type      = REQ_EVICT;
        w.map_size      = SIZE_W'($urandom());   // the rest is don't-care on an evict
        w.free_amount   = amount;
        w.corner_left   = COORD_W'($urandom());
        w.corner_top    = COORD_W'($urandom());
        w.corner_right  = COORD_W'($urandom());
        w.corner_bottom = COORD_W'($urandom());
        return w;
    endfunction

    function automatic rsp_word_t result_word(input logic [CODE_W-1:0] code,
                                              input logic [SLOT_OUT_W-1:0] slot,
                                              input logic [ID_W-1:0] id);
        rsp_word_t r;
        r.outcome     = code;
        r.slot_index  = slot;
        r.map_id      = id;
        r.freed_size  = '0;
        r.last_result = 1'b1;
        return r;
    endfunction

    // Offers one request word after a random gap, waits for it to be taken,
    // then queues its expected result words.
    task automatic offer_request(input req_word_t w, input logic typed, input rsp_word_t want);
        logic [127:0] noise;
        int           gap;
        if (tight_run > 0)
        begin
            tight_run--;
            gap = 0;
        end
        else if ($urandom_range(0, 24) == 0)
        begin
            tight_run = $urandom_range(10, 30);
            gap = 0;
        end
        else
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
        if (gap > 0)
        begin
            noise = {$urandom(), $urandom(), $urandom(), $urandom()};
            req_valid <= 1'b0;
            req_word  <= noise[$bits(req_word_t)-1:0];
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_word  <= w;
        @(posedge clk);
        while (req_stall !== 1'b0)
            @(posedge clk);
        void'(predict_map_table(w));
        if (typed)
        begin
            void'(expected_words.pop_back());
            expected_words.push_back(want);
        end
        requests_done++;
    endtask

    // Waits until every expected word is in, then lets a zero-amount evict finish.
    task automatic drain_results();
        int guard;
        guard = 0;
        req_valid <= 1'b0;
        while (expected_words.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        if (expected_words.size() != 0)
        begin
            $display("%0t: %0d expected result words never arrived, oldest %h",
                     $time, expected_words.size(), expected_words[0]);
            mismatches += expected_words.size();
            expected_words.delete();
        end
        repeat (IDLE_TAIL) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want, got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // ---- result side: compares each taken word with the oldest expectation ----
    always @(posedge clk)
    begin : result_check
        rsp_word_t want;
        if (rst_n === 1'b1 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
        begin
            results_seen++;
            if (rsp_word.outcome <= OUT_EMPTIED)
                outcome_hits[rsp_word.outcome]++;
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none got %h", $time, rsp_word);
                mismatches++;
            end
            else
            begin
                want = expected_words.pop_front();
                check_field("outcome",     32'(want.outcome),     32'(rsp_word.outcome));
                check_field("slot_index",  32'(want.slot_index),  32'(rsp_word.slot_index));
                check_field("map_id",      want.map_id,           rsp_word.map_id);
                check_field("freed_size",  32'(want.freed_size),  32'(rsp_word.freed_size));
                check_field("last_result", 32'(want.last_result), 32'(rsp_word.last_result));
            end
        end
    end

    // ---- receiver: alternating free and stalled stretches, one long hold-off ----
    initial
    begin : result_stall
        int  n;
        logic held_long;
        held_long = 1'b0;
        rsp_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            // stretches are never empty, so stall moves once per edge at most
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
            rsp_stall <= 1'b0;
            repeat (n) @(posedge clk);
            if (!held_long && results_seen >= 60)
            begin
                // sender keeps offering; the block backs up and holds req_stall
                held_long = 1'b1;
                n = LONG_HOLD;
            end
            else
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120)
                                                : $urandom_range(1, 3);
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clk);
        end
    end

    // ---- stimulus ----
    initial
    begin : stimulus
        dir_row_t  dir_rows[$];
        area_t     plan    [PHASES];
        int        add_pct [PHASES];
        req_word_t w;
        logic [CFG_IDX_W-1:0] reg_sel[4];
        logic [COORD_W-1:0]   reg_val[4];

        req_valid <= 1'b0;
        req_word  <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_AREA_LEFT;
        cfg_data  <= '0;
        rst_n     <= 1'b0;

        // shadow state after reset: empty table, highest slot on top of the stack
        for (int i = 0; i < DEPTH; i++)
        begin
            tbl_used[i]   = 1'b0;
            free_stack[i] = i;
        end
        free_top = DEPTH;
        age_now  = '0;
        id_now   = '0;
        area_now = {16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, under the reset area. Typed rows are the obvious ones.
        dir_rows.push_back({evict_word(24'd1), 1'b1, result_word(OUT_EMPTIED, 5'd0, 32'd0)});
        dir_rows.push_back({evict_word(24'd0), 1'b0, rsp_word_t'('0)});   // no result at all
        dir_rows.push_back({add_word(24'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF), 1'b1,
                            result_word(OUT_BAD, 5'd0, 32'd0)});
        dir_rows.push_back({add_word(24'd5, 16'd10, 16'd3, 16'd9, 16'd40), 1'b1,
                            result_word(OUT_BAD, 5'd0, 32'd0)});
        dir_rows.push_back({add_word(24'd5, 16'd3, 16'd10, 16'd40, 16'd9), 1'b1,
                            result_word(OUT_BAD, 5'd0, 32'd0)});
        dir_rows.push_back({add_word(24'hFFFFFF, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF), 1'b1,
                            result_word(OUT_ADDED, 5'd31, 32'd1)});
        dir_rows.push_back({add_word(24'd1, 16'd0, 16'd0, 16'd0, 16'd0), 1'b1,
                            result_word(OUT_ADDED, 5'd30, 32'd2)});
        dir_rows.push_back({add_word(24'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0,
                            rsp_word_t'('0)});
        dir_rows.push_back({add_word(24'd500, 16'd5, 16'd6, 16'd7, 16'd8), 1'b0, rsp_word_t'('0)});
        // equal sizes, but only the first of the two counts as old at the evicts below
        dir_rows.push_back({add_word(24'd500, 16'd1, 16'd2, 16'd3, 16'd4), 1'b0, rsp_word_t'('0)});
        dir_rows.push_back({add_word(24'd700, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA), 1'b0,
                            rsp_word_t'('0)});
        // only stamps 1..4 count as old here; the big one goes first
        dir_rows.push_back({evict_word(24'd1), 1'b0, rsp_word_t'('0)});
        dir_rows.push_back({evict_word(24'd600), 1'b0, rsp_word_t'('0)});
        dir_rows.push_back({add_word(24'hABCDEF, 16'h1234, 16'h0F0F, 16'hF00D, 16'hF0F0), 1'b0,
                            rsp_word_t'('0)});
        dir_rows.push_back({evict_word(24'd1), 1'b0, rsp_word_t'('0)});
        // amount larger than everything stored: drains and reports emptied
        dir_rows.push_back({evict_word(24'hFFFFFF), 1'b0, rsp_word_t'('0)});
        dir_rows.push_back({evict_word(24'd10), 1'b0, rsp_word_t'('0)});
        dir_rows.push_back({add_word(24'h800000, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0,
                            rsp_word_t'('0)});
        dir_rows.push_back({evict_word(24'h7FFFFF), 1'b0, rsp_word_t'('0)});

        foreach (dir_rows[k])
            offer_request(dir_rows[k].word, dir_rows[k].typed, dir_rows[k].want);

        // Random phases: each under its own area. Early phases lean on adds so the
        // table fills and reports full; later ones give evicts a larger share.
        plan[0] = {16'd100,   16'd200,   16'd1000,  16'd2000};
        plan[1] = {16'h0000,  16'h0000,  16'h0000,  16'h0000};
        plan[2] = {16'h0000,  16'h0000,  16'hFFFF,  16'hFFFF};
        plan[3] = {16'hFFFF,  16'hFFFF,  16'hFFFF,  16'hFFFF};
        add_pct = '{90, 70, 50, 60};

        for (int p = 0; p < PHASES; p++)
        begin
            drain_results();
            reg_sel = '{REG_AREA_LEFT, REG_AREA_TOP, REG_AREA_RIGHT, REG_AREA_BOTTOM};
            reg_val = '{plan[p].left, plan[p].top, plan[p].right, plan[p].bottom};
            for (int r = 0; r < 4; r++)
            begin
                cfg_valid <= 1'b1;
                cfg_index <= reg_sel[r];
                cfg_data  <= reg_val[r];
                @(posedge clk);
                while (cfg_ready !== 1'b1)
                    @(posedge clk);
            end
            cfg_valid <= 1'b0;
            area_now = plan[p];

            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                w = evict_word(SIZE_W'($urandom()));   // an evict with all other fields random to start with
                if ($urandom_range(0, 99) < add_pct[p])
                begin
                    w.req_type    = REQ_ADD;
                    w.free_amount = SIZE_W'($urandom());
                    case ($urandom_range(0, 9))
                        0:       w.map_size = 24'hFFFFFF;
                        1:       w.map_size = SIZE_W'($urandom_range(1, 24'hFFFFFF));
                        default: w.map_size = SIZE_W'($urandom_range(1, 4000));
                    endcase
                    // well-formed rectangle inside the area
                    w.corner_left   = COORD_W'($urandom_range(area_now.right, area_now.left));
                    w.corner_top    = COORD_W'($urandom_range(area_now.bottom, area_now.top));
                    w.corner_right  = COORD_W'($urandom_range(area_now.right, w.corner_left));
                    w.corner_bottom = COORD_W'($urandom_range(area_now.bottom, w.corner_top));
                    if ($urandom_range(0, 99) < 15)
                    begin
                        // broken request of some kind; the random-corner choices can still come out valid
                        case ($urandom_range(0, 5))
                            0: w.map_size = '0;
                            1:
                            begin
                                w.corner_left  = COORD_W'($urandom_range(1, 16'hFFFF));
                                w.corner_right = COORD_W'($urandom_range(0, w.corner_left - 1));
                            end
                            2:
                            begin
                                w.corner_top    = COORD_W'($urandom_range(1, 16'hFFFF));
                                w.corner_bottom = COORD_W'($urandom_range(0, w.corner_top - 1));
                            end
                            3:
                                if (area_now.left > 0)
                                    w.corner_left =
                                        COORD_W'($urandom_range(0, area_now.left - 1));
                                else
                                    w.corner_top = COORD_W'($urandom());
                            4:
                                if (area_now.right < 16'hFFFF)
                                    w.corner_right =
                                        COORD_W'($urandom_range(area_now.right + 1, 16'hFFFF));
                                else
                                    w.corner_bottom = COORD_W'($urandom());
                            default:
                            begin
                                w.corner_left   = COORD_W'($urandom());
                                w.corner_top    = COORD_W'($urandom());
                                w.corner_right  = COORD_W'($urandom());
                                w.corner_bottom = COORD_W'($urandom());
                            end
                        endcase
                    end
                end
                else
                begin
                    case ($urandom_range(0, 9))
                        0:       w.free_amount = '0;
                        1:       w.free_amount = 24'hFFFFFF;
                        2, 3:    w.free_amount = SIZE_W'($urandom());
                        default: w.free_amount = SIZE_W'($urandom_range(1, 6000));
                    endcase
                end
                offer_request(w, 1'b0, rsp_word_t'('0));
            end
        end

        drain_results();
        $display("Run covered %0d requests and %0d result words over %0d area settings.",
                 requests_done, results_seen, PHASES + 1);
        $display("Outcomes: added %0d, evicted %0d, bad %0d, full %0d, emptied %0d; %0d mismatches.",
                 outcome_hits[OUT_ADDED], outcome_hits[OUT_EVICTED], outcome_hits[OUT_BAD],
                 outcome_hits[OUT_FULL], outcome_hits[OUT_EMPTIED], mismatches);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // ---- run limit ----
    initial
    begin : watchdog
        #(RUN_LIMIT_NS);
        $display("%0t: run limit reached with %0d words still expected",
                 $time, expected_words.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/core/mtse_pkg.sv
rtl/core/mtse_ctrl.sv
rtl/core/mtse_dpath.sv
rtl/core/map_table_size_age_eviction.sv
bench/tb_top.sv
